/* design/ilr_pkg.sv */
// Shared types, constants and helpers for the idempotency ledger ring.
package ilr_pkg;

    localparam int PRINCIPALS   = 16;
    localparam int DEPTH        = 8;
    localparam int PAYLOAD_BITS = 32;

    localparam int P_W    = (PRINCIPALS > 1) ? $clog2(PRINCIPALS) : 1;
    localparam int D_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOTS  = PRINCIPALS * DEPTH;
    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    typedef enum logic [2:0] {
        ST_MISS     = 3'd0,
        ST_SAME     = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_STORED   = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOOK
    } t_state;

    typedef struct packed {
        logic [31:0]             epoch;
        logic [31:0]             txn_id;
        logic [31:0]             fingerprint;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_slot;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_slot             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] hit_txn_id;
        logic [31:0] hit_fingerprint;
        logic [31:0] hit_payload;
        logic [3:0]  occupancy;
        logic        evicted_now;
        logic [31:0] evicted_total;
    } t_result;

    // ring position (head + offset) modulo DEPTH; both operands below DEPTH
    function automatic logic [D_W-1:0] wrap_pos(input logic [D_W-1:0] head,
                                                input logic [CNT_W-1:0] ofs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(ofs);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[D_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [P_W-1:0] p,
                                                    input logic [D_W-1:0] pos);
        return ADDR_W'(int'(p) * DEPTH + int'(pos));
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] pl_in(input logic [31:0] x);
        logic [63:0] t;
        t = {32'b0, x};
        return t[PAYLOAD_BITS-1:0];
    endfunction

    function automatic logic [31:0] pl_out(input logic [PAYLOAD_BITS-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[31:0];
    endfunction

    function automatic logic [3:0] occ_out(input logic [CNT_W-1:0] c);
        logic [7:0] t;
        t = 8'(c);
        return t[3:0];
    endfunction

endpackage

/* design/ilr_slot_ram.sv */
// Slot memory: one write port, one registered read port.
module ilr_slot_ram
    import ilr_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_slot    o_rdata
);

    t_slot r_mem [SLOTS];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/ilr_ctrl.sv */
// Sequencer: ring pointers, eviction count, store path and ring scan.
module ilr_ctrl
    import ilr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_epoch,
    input  logic [15:0] i_principal,
    input  logic [31:0] i_txn_id,
    input  logic [31:0] i_fingerprint,
    input  logic [31:0] i_payload,
    input  logic        i_out_free,
    output logic        o_res_load,
    output t_result     o_res,
    output t_ram_req    o_ram_req,
    input  t_slot       i_rdata
);

    t_state           r_state, n_state;
    logic             r_op, n_op;
    logic [31:0]      r_epoch, n_epoch;
    logic [15:0]      r_principal, n_principal;
    logic [31:0]      r_rid, n_rid;
    logic [31:0]      r_fp, n_fp;
    logic [31:0]      r_payload, n_payload;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_cmp_valid, n_cmp_valid;
    logic [D_W-1:0]   r_head [PRINCIPALS];
    logic [CNT_W-1:0] r_count [PRINCIPALS];
    logic [31:0]      r_evict_total, n_evict_total;

    logic             upd_ring;
    logic [D_W-1:0]   n_head_sel;
    logic [CNT_W-1:0] n_count_sel;

    logic [P_W-1:0]   pidx;
    logic             in_range;
    logic [D_W-1:0]   head;
    logic [CNT_W-1:0] cnt;
    logic             full;
    logic             key_hit;
    logic [D_W-1:0]   wpos;

    assign pidx     = r_principal[P_W-1:0];
    assign in_range = (r_principal < 16'(PRINCIPALS));
    assign head     = r_head[pidx];
    assign cnt      = r_count[pidx];
    assign full     = (cnt >= CNT_W'(DEPTH));
    assign key_hit  = r_cmp_valid && (i_rdata.epoch == r_epoch)
                      && (i_rdata.txn_id == r_rid);
    assign wpos     = full ? head : wrap_pos(head, cnt);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_epoch       = r_epoch;
        n_principal   = r_principal;
        n_rid         = r_rid;
        n_fp          = r_fp;
        n_payload     = r_payload;
        n_idx         = r_idx;
        n_cmp_valid   = r_cmp_valid;
        n_evict_total = r_evict_total;
        upd_ring      = 1'b0;
        n_head_sel    = head;
        n_count_sel   = cnt;
        o_in_stall    = (r_state != S_IDLE);
        o_res_load    = 1'b0;
        o_res         = '0;
        o_res.evicted_total = r_evict_total;
        o_ram_req       = '0;
        o_ram_req.raddr = slot_addr(pidx, wrap_pos(head, r_idx));
        o_ram_req.waddr = slot_addr(pidx, wpos);
        o_ram_req.wdata = '{epoch: r_epoch, txn_id: r_rid,
                            fingerprint: r_fp, payload: pl_in(r_payload)};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op        = i_opcode;
                    n_epoch     = i_epoch;
                    n_principal = i_principal;
                    n_rid       = i_txn_id;
                    n_fp        = i_fingerprint;
                    n_payload   = i_payload;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (!in_range) begin
                    if (i_out_free) begin
                        o_res_load   = 1'b1;
                        o_res.status = ST_RANGE;
                        n_state      = S_IDLE;
                    end
                end else if (r_op == OP_STORE) begin
                    if (i_out_free) begin
                        o_ram_req.we = 1'b1;
                        upd_ring     = 1'b1;
                        if (full) begin
                            n_head_sel    = (head == D_W'(DEPTH - 1)) ? '0 : head + 1'b1;
                            n_evict_total = r_evict_total + 32'd1;
                        end else begin
                            n_count_sel = cnt + 1'b1;
                        end
                        o_res_load          = 1'b1;
                        o_res.status        = ST_STORED;
                        o_res.occupancy     = occ_out(n_count_sel);
                        o_res.evicted_now   = full;
                        o_res.evicted_total = n_evict_total;
                        n_state             = S_IDLE;
                    end
                end else if (cnt == '0) begin
                    if (i_out_free) begin
                        o_res_load   = 1'b1;
                        o_res.status = ST_MISS;
                        n_state      = S_IDLE;
                    end
                end else begin
                    n_idx       = '0;
                    n_cmp_valid = 1'b0;
                    n_state     = S_LOOK;
                end
            end
            S_LOOK: begin
                priority if (key_hit) begin
                    if (i_out_free) begin
                        o_res_load      = 1'b1;
                        o_res.occupancy = occ_out(cnt);
                        if (i_rdata.fingerprint == r_fp) begin
                            o_res.status          = ST_SAME;
                            o_res.hit_txn_id      = i_rdata.txn_id;
                            o_res.hit_fingerprint = i_rdata.fingerprint;
                            o_res.hit_payload     = pl_out(i_rdata.payload);
                        end else begin
                            o_res.status = ST_CONFLICT;
                        end
                        n_state = S_IDLE;
                    end
                end else if (r_idx == cnt) begin
                    if (i_out_free) begin
                        o_res_load      = 1'b1;
                        o_res.status    = ST_MISS;
                        o_res.occupancy = occ_out(cnt);
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_ram_req.re = 1'b1;
                    n_idx        = r_idx + 1'b1;
                    n_cmp_valid  = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cmp_valid   <= 1'b0;
            r_idx         <= '0;
            r_evict_total <= '0;
            for (int k = 0; k < PRINCIPALS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_cmp_valid   <= n_cmp_valid;
            r_idx         <= n_idx;
            r_evict_total <= n_evict_total;
            if (upd_ring) begin
                r_head[pidx]  <= n_head_sel;
                r_count[pidx] <= n_count_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_epoch     <= n_epoch;
        r_principal <= n_principal;
        r_rid       <= n_rid;
        r_fp        <= n_fp;
        r_payload   <= n_payload;
    end

endmodule

/* design/idempotency_ledger_ring.sv */
// Sequencing: a store, an out-of-range request or a lookup on an empty ring is resolved
// in S_EXEC; a lookup over held entries goes on from S_EXEC to scan the ring in S_LOOK.
// Throughput: one item at a time; a lookup scans one slot per cycle through the single
// read port of the slot memory. Each result is held in the output register.
// Reset: synchronous, active low; clears ring heads, counts and the eviction count.
// The slot memory is not cleared: only held entries are ever read.
module idempotency_ledger_ring
    import ilr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [31:0] i_epoch,
    input  logic [15:0] i_principal,
    input  logic [31:0] i_txn_id,
    input  logic [31:0] i_fingerprint,
    input  logic [31:0] i_payload,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_hit_txn_id,
    output logic [31:0] o_hit_fingerprint,
    output logic [31:0] o_hit_payload,
    output logic [3:0]  o_occupancy,
    output logic        o_evicted_now,
    output logic [31:0] o_evicted_total
);

    t_ram_req ram_req;
    t_slot    rdata;
    logic     res_load;
    t_result  res;
    logic     out_free;
    logic     r_out_valid;
    t_result  r_res;

    assign out_free = !r_out_valid || !i_out_stall;

    ilr_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    ilr_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_epoch       (i_epoch),
        .i_principal   (i_principal),
        .i_txn_id      (i_txn_id),
        .i_fingerprint (i_fingerprint),
        .i_payload     (i_payload),
        .i_out_free    (out_free),
        .o_res_load    (res_load),
        .o_res         (res),
        .o_ram_req     (ram_req),
        .i_rdata       (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_res.status;
    assign o_hit_txn_id      = r_res.hit_txn_id;
    assign o_hit_fingerprint = r_res.hit_fingerprint;
    assign o_hit_payload     = r_res.hit_payload;
    assign o_occupancy       = r_res.occupancy;
    assign o_evicted_now     = r_res.evicted_now;
    assign o_evicted_total   = r_res.evicted_total;

endmodule

/* design/ilr_checker.sv */
// Port-level checks for the idempotency ledger ring, bound to the top level.
module ilr_checker
    import ilr_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_status,
    input logic [31:0] o_hit_txn_id,
    input logic [31:0] o_hit_fingerprint,
    input logic [31:0] o_hit_payload,
    input logic [3:0]  o_occupancy,
    input logic        o_evicted_now,
    input logic [31:0] o_evicted_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_evicted_total))
        else $error("stalled result beat changed");

    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_RANGE) |-> (o_occupancy == 4'd0) && !o_evicted_now)
        else $error("out-of-range result reports occupancy or eviction");

    a_evict_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_evicted_now |-> (o_status == ST_STORED))
        else $error("eviction flagged on a non-store result");

    a_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_SAME) |->
            (o_hit_txn_id == 32'd0) && (o_hit_fingerprint == 32'd0)
            && (o_hit_payload == 32'd0))
        else $error("hit fields set without a same-result status");

    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall ##1 o_out_valid && (o_status != ST_STORED)
            |-> $stable(o_evicted_total))
        else $error("eviction count moved on a non-store result");

endmodule

bind idempotency_ledger_ring ilr_checker u_ilr_checker (.*);
